// ===== src/cam_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cam_pkg
// Shared types and calendar constants for the calendar minute adder.
// ----------------------------------------------------------------------------
package cam_pkg;

	localparam int ACC_W  = 31;    // minute accumulator width
	localparam int YCNT_W = 13;    // year counter width, covers carry past 4095
	localparam int MIN_W  = 27;    // total_minutes field width

	localparam logic [ACC_W-1:0] MIN_PER_DAY  = ACC_W'(1440);
	localparam logic [ACC_W-1:0] MIN_PER_YEAR = ACC_W'(525600);

	// Datapath commands, at most one active per cycle
	typedef struct packed {
		logic load;      // capture an input item
		logic prep1;     // reciprocal step for start-year leap test, day sum
		logic prep2;     // finish start leap test, form minutes within year
		logic fwd_step;  // add one whole year before the start year
		logic add_ofs;   // add the offset, restart the year counter
		logic bwd_step;  // remove one whole year from the remainder
		logic mon_step;  // remove one whole month from the remainder
		logic day;       // quotient of remainder by minutes per day
		logic hr;        // drop whole days from the remainder
		logic mins;      // quotient of remainder by minutes per hour
		logic fin;       // load the output registers
	} cam_cmd_t;

	typedef struct packed {
		logic fwd_done;  // year counter reached the start year
		logic bwd_done;  // remainder below the current year length
		logic mon_done;  // remainder inside the current month
	} cam_sts_t;

	// Days before the first of a month in a common year
	function automatic logic [8:0] days_before(input logic [3:0] m);
		logic [8:0] d;
		unique case (m)
			4'd1:    d = 9'd0;
			4'd2:    d = 9'd31;
			4'd3:    d = 9'd59;
			4'd4:    d = 9'd90;
			4'd5:    d = 9'd120;
			4'd6:    d = 9'd151;
			4'd7:    d = 9'd181;
			4'd8:    d = 9'd212;
			4'd9:    d = 9'd243;
			4'd10:   d = 9'd273;
			4'd11:   d = 9'd304;
			4'd12:   d = 9'd334;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

	// Length of a month in a common year
	function automatic logic [4:0] month_days(input logic [3:0] m);
		logic [4:0] d;
		unique case (m)
			4'd2:                       d = 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:    d = 5'd30;
			default:                    d = 5'd31;
		endcase
		return d;
	endfunction

endpackage

// ===== src/cam_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cam_ctrl
// Sequencer for the calendar minute adder: steps the datapath through the
// forward year walk, offset add, backward year and month walk and output.
// ----------------------------------------------------------------------------
module cam_ctrl
	import cam_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  cam_sts_t sts,
	output cam_cmd_t cmd
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_PREP1 = 4'd1;
	localparam logic [3:0] ST_PREP2 = 4'd2;
	localparam logic [3:0] ST_FWD   = 4'd3;
	localparam logic [3:0] ST_BWD   = 4'd4;
	localparam logic [3:0] ST_MON   = 4'd5;
	localparam logic [3:0] ST_DAY   = 4'd6;
	localparam logic [3:0] ST_HR    = 4'd7;
	localparam logic [3:0] ST_MIN   = 4'd8;
	localparam logic [3:0] ST_FIN   = 4'd9;

	logic [3:0] state_q, state_d;
	logic       out_valid_q;
	logic       out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_PREP1;
				end
			end
			ST_PREP1: begin
				cmd.prep1 = 1'b1;
				state_d   = ST_PREP2;
			end
			ST_PREP2: begin
				cmd.prep2 = 1'b1;
				state_d   = ST_FWD;
			end
			ST_FWD: begin
				if (sts.fwd_done) begin
					cmd.add_ofs = 1'b1;
					state_d     = ST_BWD;
				end else begin
					cmd.fwd_step = 1'b1;
				end
			end
			ST_BWD: begin
				if (sts.bwd_done) begin
					state_d = ST_MON;
				end else begin
					cmd.bwd_step = 1'b1;
				end
			end
			ST_MON: begin
				if (sts.mon_done) begin
					state_d = ST_DAY;
				end else begin
					cmd.mon_step = 1'b1;
				end
			end
			ST_DAY: begin
				cmd.day = 1'b1;
				state_d = ST_HR;
			end
			ST_HR: begin
				cmd.hr  = 1'b1;
				state_d = ST_MIN;
			end
			ST_MIN: begin
				cmd.mins = 1'b1;
				state_d  = ST_FIN;
			end
			ST_FIN: begin
				if (out_free) begin
					cmd.fin = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.fin) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== src/cam_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cam_dpath
// Datapath of the calendar minute adder: minute accumulator, year counter
// with leap-cycle counters, month counter and output registers.
// ----------------------------------------------------------------------------
module cam_dpath
	import cam_pkg::*;
#(
	parameter int BASE_YEAR_VALUE = 2000,
	parameter int YEAR_SPAN       = 128
) (
	input  logic        clk,
	input  cam_cmd_t    cmd,
	output cam_sts_t    sts,
	input  logic [11:0] start_year,
	input  logic [3:0]  start_month,
	input  logic [4:0]  start_day,
	input  logic [4:0]  start_hour,
	input  logic [5:0]  start_minute,
	input  logic [25:0] minutes_to_add,
	output logic [11:0] end_year,
	output logic [3:0]  end_month,
	output logic [4:0]  end_day,
	output logic [4:0]  end_hour,
	output logic [5:0]  end_minute,
	output logic [26:0] total_minutes,
	output logic        out_of_range
);

	localparam logic [YCNT_W-1:0] BASE_Y   = YCNT_W'(BASE_YEAR_VALUE);
	localparam logic [1:0]        BASE_M4  = 2'(BASE_YEAR_VALUE % 4);
	localparam logic [6:0]        BASE_M100 = 7'(BASE_YEAR_VALUE % 100);
	localparam logic [8:0]        BASE_M400 = 9'(BASE_YEAR_VALUE % 400);
	localparam logic [YCNT_W:0]   SPAN_END = (YCNT_W+1)'(BASE_YEAR_VALUE + YEAR_SPAN);

	// captured item
	logic [11:0] yr_q;
	logic [3:0]  mon_q;
	logic [4:0]  dayz_q;
	logic [4:0]  hour_q;
	logic [5:0]  min_q;
	logic [25:0] ofs_q;

	logic [7:0]        yq_q;     // start_year / 25
	logic [8:0]        days_q;   // days before the start date in its year
	logic [ACC_W-1:0]  acc_q;    // running minutes, later the remainder
	logic [ACC_W-1:0]  tot_q;
	logic [YCNT_W-1:0] ycnt_q;
	logic [1:0]        m4_q;
	logic [6:0]        m100_q;
	logic [8:0]        m400_q;
	logic [3:0]        mcnt_q;
	logic [4:0]        dq_q;     // whole days left in the month
	logic [4:0]        hq_q;     // whole hours left in the day

	logic [3:0]        mon_c;
	logic [4:0]        day_c;
	logic              cnt_leap;
	logic              div25;
	logic              start_leap;
	logic [8:0]        days_adj;
	logic [ACC_W-1:0]  hm_min;
	logic [ACC_W-1:0]  ylen;
	logic [ACC_W-1:0]  mlen;
	logic [24:0]       yr_prod;
	logic [21:0]       dq_prod;
	logic [21:0]       hq_prod;
	logic [15:0]       day_min;
	logic [10:0]       hr_min;

	// clamp month to 1..12 and day to at least 1
	assign mon_c = (start_month == 4'd0) ? 4'd1 :
	               (start_month > 4'd12) ? 4'd12 : start_month;
	assign day_c = (start_day == 5'd0) ? 5'd1 : start_day;

	// leap test of the counted year
	assign cnt_leap = (m400_q == 9'd0) || ((m100_q != 7'd0) && (m4_q == 2'd0));

	// start year leap test; divisibility by 25 from yq_q
	assign div25      = ({yq_q, 4'b0} + {1'b0, yq_q, 3'b0} + {4'b0, yq_q}) == yr_q;
	assign start_leap = (yr_q[1:0] == 2'd0) && (!div25 || (yr_q[3:0] == 4'd0));
	assign days_adj   = days_q + {8'd0, (start_leap && (mon_q > 4'd2))};
	assign hm_min     = (ACC_W'(hour_q) << 6) - (ACC_W'(hour_q) << 2) + ACC_W'(min_q);

	assign ylen = MIN_PER_YEAR + (cnt_leap ? MIN_PER_DAY : '0);
	assign mlen = ACC_W'(month_days(mcnt_q)) * MIN_PER_DAY
	            + ((cnt_leap && (mcnt_q == 4'd2)) ? MIN_PER_DAY : '0);

	assign yr_prod = 25'(yr_q) * 25'd5243;
	assign dq_prod = 22'(acc_q[15:5]) * 22'd1457;
	assign hq_prod = 22'(acc_q[10:0]) * 22'd1093;
	assign day_min = 16'(dq_q) * 16'd1440;
	assign hr_min  = (11'(hq_q) << 6) - (11'(hq_q) << 2);

	assign sts.fwd_done = (ycnt_q >= YCNT_W'(yr_q));
	assign sts.bwd_done = (acc_q < ylen);
	assign sts.mon_done = (mcnt_q == 4'd12) || (acc_q < mlen);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			yr_q   <= start_year;
			mon_q  <= mon_c;
			dayz_q <= day_c - 5'd1;
			hour_q <= start_hour;
			min_q  <= start_minute;
			ofs_q  <= minutes_to_add;
		end
		if (cmd.prep1) begin
			yq_q   <= yr_prod[24:17];
			days_q <= 9'(dayz_q) + days_before(mon_q);
		end
		if (cmd.prep2) begin
			acc_q <= ACC_W'(days_adj) * MIN_PER_DAY + hm_min;
		end
		if (cmd.prep2 || cmd.add_ofs) begin
			ycnt_q <= BASE_Y;
			m4_q   <= BASE_M4;
			m100_q <= BASE_M100;
			m400_q <= BASE_M400;
			mcnt_q <= 4'd1;
		end
		if (cmd.fwd_step || cmd.bwd_step) begin
			ycnt_q <= ycnt_q + YCNT_W'(1);
			m4_q   <= m4_q + 2'd1;
			m100_q <= (m100_q == 7'd99) ? 7'd0 : m100_q + 7'd1;
			m400_q <= (m400_q == 9'd399) ? 9'd0 : m400_q + 9'd1;
		end
		if (cmd.fwd_step) begin
			acc_q <= acc_q + ylen;
		end
		if (cmd.add_ofs) begin
			acc_q <= acc_q + ACC_W'(ofs_q);
			tot_q <= acc_q + ACC_W'(ofs_q);
		end
		if (cmd.bwd_step) begin
			acc_q <= acc_q - ylen;
		end
		if (cmd.mon_step) begin
			acc_q  <= acc_q - mlen;
			mcnt_q <= mcnt_q + 4'd1;
		end
		if (cmd.day) begin
			dq_q <= dq_prod[20:16];
		end
		if (cmd.hr) begin
			acc_q <= ACC_W'(acc_q[15:0] - day_min);
		end
		if (cmd.mins) begin
			hq_q <= hq_prod[20:16];
		end
		if (cmd.fin) begin
			end_year      <= ycnt_q[YCNT_W-1] ? 12'hFFF : ycnt_q[11:0];
			end_month     <= mcnt_q;
			end_day       <= dq_q + 5'd1;
			end_hour      <= hq_q;
			end_minute    <= 6'(acc_q[10:0] - hr_min);
			total_minutes <= (tot_q[ACC_W-1:MIN_W] != '0) ? '1 : tot_q[MIN_W-1:0];
			out_of_range  <= ({1'b0, ycnt_q} >= SPAN_END);
		end
	end

endmodule

// ===== src/calendar_add_minutes_core.sv =====
`timescale 1ns / 1ps
// The minute accumulator steps one year per cycle in each direction, one
// month per cycle afterwards.
// Throughput: one item at a time; the next item is accepted once the previous
// result has moved into the output register.
// Reset clears the sequencer and the output valid flag; payload is not reset.
// ----------------------------------------------------------------------------
// calendar_add_minutes_core
// Adds a minute offset to a calendar date and time (Gregorian leap rules),
// returning the new date, the minute count since the base year and a span flag.
// ----------------------------------------------------------------------------
module calendar_add_minutes_core
	import cam_pkg::*;
#(
	parameter int BASE_YEAR_VALUE = 2000,
	parameter int YEAR_SPAN       = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [11:0] start_year,
	input  logic [3:0]  start_month,
	input  logic [4:0]  start_day,
	input  logic [4:0]  start_hour,
	input  logic [5:0]  start_minute,
	input  logic [25:0] minutes_to_add,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [11:0] end_year,
	output logic [3:0]  end_month,
	output logic [4:0]  end_day,
	output logic [4:0]  end_hour,
	output logic [5:0]  end_minute,
	output logic [26:0] total_minutes,
	output logic        out_of_range
);

	// command and status between sequencer and datapath
	cam_cmd_t cmd;
	cam_sts_t sts;

	// Sequencer: capture an item, walk years forward to the start year, add
	// the offset, walk years and months back out of the sum, split the rest
	// into day, hour and minute, then hold until the output register frees.
	cam_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Datapath: the accumulator holds minutes since the base year going
	// forward and the remainder going back; leap years come from modulo
	// counters that advance with the year counter.
	cam_dpath #(
		.BASE_YEAR_VALUE (BASE_YEAR_VALUE),
		.YEAR_SPAN       (YEAR_SPAN)
	) u_dpath (
		.clk            (clk),
		.cmd            (cmd),
		.sts            (sts),
		.start_year     (start_year),
		.start_month    (start_month),
		.start_day      (start_day),
		.start_hour     (start_hour),
		.start_minute   (start_minute),
		.minutes_to_add (minutes_to_add),
		.end_year       (end_year),
		.end_month      (end_month),
		.end_day        (end_day),
		.end_hour       (end_hour),
		.end_minute     (end_minute),
		.total_minutes  (total_minutes),
		.out_of_range   (out_of_range)
	);

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the calendar minute adder against its own date arithmetic. Each
// date and offset sent in is converted to the expected end date, minute count
// and span flag. Every result that leaves the block is compared with the
// oldest of those, under random stalls on both handshakes.
// ----------------------------------------------------------------------------
module testbench;

	// Calendar constants, kept local so the prediction does not lean on the RTL
	localparam int              EPOCH_YEAR     = 2000;
	localparam int              YEAR_SPAN      = 128;
	localparam longint unsigned MIN_PER_HOUR   = 60;
	localparam longint unsigned MIN_PER_DAY    = 1440;
	localparam longint unsigned MIN_PER_YEAR   = 525600;
	localparam longint unsigned TOTAL_MAX      = 134217727;
	localparam longint unsigned YEAR_FIELD_MAX = 4095;
	localparam int              MAX_REPORTS    = 10;
	localparam int              SETTLE_CYCLES  = 4500;  // longest single conversion

	// One starting date plus the offset to add
	typedef struct {
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [25:0] offset;
	} date_stamp_t;

	// The date after the offset has been added
	typedef struct {
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [26:0] total;
		logic        past_span;
	} shifted_date_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [11:0] start_year;
	logic [3:0]  start_month;
	logic [4:0]  start_day;
	logic [4:0]  start_hour;
	logic [5:0]  start_minute;
	logic [25:0] minutes_to_add;
	logic        out_valid;
	logic        out_ready;
	logic [11:0] end_year;
	logic [3:0]  end_month;
	logic [4:0]  end_day;
	logic [4:0]  end_hour;
	logic [5:0]  end_minute;
	logic [26:0] total_minutes;
	logic        out_of_range;

	// Dates still owed by the block, oldest first
	shifted_date_t shifted_dates_due[$];
	int            mismatch_count = 0;
	bit            sender_gaps    = 1'b1;
	bit            receiver_stalls = 1'b1;

	calendar_add_minutes_core #(
		.BASE_YEAR_VALUE(EPOCH_YEAR),
		.YEAR_SPAN      (YEAR_SPAN)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.start_year    (start_year),
		.start_month   (start_month),
		.start_day     (start_day),
		.start_hour    (start_hour),
		.start_minute  (start_minute),
		.minutes_to_add(minutes_to_add),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.end_year      (end_year),
		.end_month     (end_month),
		.end_day       (end_day),
		.end_hour      (end_hour),
		.end_minute    (end_minute),
		.total_minutes (total_minutes),
		.out_of_range  (out_of_range)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Calendar arithmetic
	// ------------------------------------------------------------------------

	// Gregorian rule: every fourth year, except centuries not divisible by 400
	function automatic bit gregorian_leap(longint unsigned y);
		if (y % 400 == 0) return 1'b1;
		if (y % 100 == 0) return 1'b0;
		return (y % 4 == 0);
	endfunction

	// Month length; anything outside 1..12 falls to 31 days
	function automatic int unsigned days_in_month(int unsigned m, bit leap);
		case (m)
			2:          return leap ? 29 : 28;
			4, 6, 9, 11: return 30;
			default:    return 31;
		endcase
	endfunction

	function automatic longint unsigned minutes_in_year(longint unsigned y);
		return MIN_PER_YEAR + (gregorian_leap(y) ? MIN_PER_DAY : 0);
	endfunction

	// Convert the start to minutes since the base year, add the offset, and
	// walk back out through whole years, then whole months.
	function automatic shifted_date_t shift_date_by_minutes(date_stamp_t s);
		shifted_date_t   r;
		longint unsigned total;
		longint unsigned rem;
		longint unsigned yr;
		int unsigned     mon;
		int unsigned     dom;
		int unsigned     yday;
		bit              leap;
		// Clamp month into 1..12 and lift day zero to the first
		mon = (s.month == 4'd0) ? 1 : ((s.month > 4'd12) ? 12 : s.month);
		dom = (s.day == 5'd0) ? 1 : s.day;
		leap = gregorian_leap(s.year);
		// Oversized day, hour and minute simply carry forward
		total = s.minute + s.hour * MIN_PER_HOUR + (dom - 1) * MIN_PER_DAY;
		for (int unsigned m = 1; m < mon; m++)
			total += days_in_month(m, leap) * MIN_PER_DAY;
		// Years before the base add nothing here
		for (longint unsigned y = EPOCH_YEAR; y < s.year; y++)
			total += minutes_in_year(y);
		total += s.offset;

		rem = total;
		yr = EPOCH_YEAR;
		while (rem >= minutes_in_year(yr)) begin
			rem -= minutes_in_year(yr);
			yr++;
		end
		leap = gregorian_leap(yr);
		yday = rem / MIN_PER_DAY;
		rem -= yday * MIN_PER_DAY;
		mon = 1;
		while (mon < 12 && yday >= days_in_month(mon, leap)) begin
			yday -= days_in_month(mon, leap);
			mon++;
		end

		r.year      = (yr > YEAR_FIELD_MAX) ? 12'hFFF : 12'(yr);
		r.month     = 4'(mon);
		r.day       = 5'(yday + 1);
		r.hour      = 5'(rem / MIN_PER_HOUR);
		r.minute    = 6'(rem % MIN_PER_HOUR);
		r.total     = (total > TOTAL_MAX) ? 27'(TOTAL_MAX) : 27'(total);
		r.past_span = (yr - EPOCH_YEAR) >= YEAR_SPAN;
		return r;
	endfunction

	function automatic date_stamp_t make_stamp(int y, int mo, int d, int h, int mi,
			longint unsigned ofs);
		date_stamp_t s;
		s.year   = 12'(y);
		s.month  = 4'(mo);
		s.day    = 5'(d);
		s.hour   = 5'(h);
		s.minute = 6'(mi);
		s.offset = 26'(ofs);
		return s;
	endfunction

	// Mostly sane dates inside the span; some below the base, some past it,
	// some with fields out of range, and some on the last minute of a month.
	// A wide year spans the whole field and makes the conversion slow.
	function automatic date_stamp_t random_date_stamp(bit wide_year);
		date_stamp_t s;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (wide_year)
			s.year = 12'($urandom_range(0, 4095));
		else if (pick < 80)
			s.year = 12'($urandom_range(EPOCH_YEAR, EPOCH_YEAR + YEAR_SPAN - 1));
		else if (pick < 92)
			s.year = 12'($urandom_range(0, EPOCH_YEAR - 1));
		else
			s.year = 12'($urandom_range(EPOCH_YEAR + YEAR_SPAN, EPOCH_YEAR + 300));
		s.month = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
		                                      : 4'($urandom_range(1, 12));

		pick = $urandom_range(0, 99);
		if (pick < 35)
			s.offset = 26'($urandom_range(0, 10000));
		else if (pick < 65)
			s.offset = 26'($urandom_range(0, (1 << 20) - 1));
		else
			s.offset = 26'($urandom);

		pick = $urandom_range(0, 99);
		if (pick < 10) begin
			// Last minute of the month, nudged over the boundary
			s.day    = 5'(days_in_month(s.month, gregorian_leap(s.year)));
			s.hour   = 5'd23;
			s.minute = 6'd59;
			s.offset = 26'($urandom_range(0, 2));
		end else if (pick < 22) begin
			s.day    = 5'($urandom_range(0, 31));
			s.hour   = 5'($urandom_range(0, 31));
			s.minute = 6'($urandom_range(0, 63));
		end else begin
			s.day    = 5'($urandom_range(1, days_in_month(s.month, gregorian_leap(s.year))));
			s.hour   = 5'($urandom_range(0, 23));
			s.minute = 6'($urandom_range(0, 59));
		end
		return s;
	endfunction

	// ------------------------------------------------------------------------
	// Handshake drivers
	// ------------------------------------------------------------------------

	// Present one item and hold it until the block takes it. Valid stays up
	// between back-to-back items; it only drops for a gap.
	task automatic send_date(input date_stamp_t s);
		if (sender_gaps && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_valid       <= 1'b1;
		start_year     <= s.year;
		start_month    <= s.month;
		start_day      <= s.day;
		start_hour     <= s.hour;
		start_minute   <= s.minute;
		minutes_to_add <= s.offset;
		do @(posedge clk); while (!in_ready);
		shifted_dates_due.push_back(shift_date_by_minutes(s));
	endtask

	// Stall the result side in short bursts, with quiet stretches in between
	initial begin : result_stalls
		int burst;
		out_ready = 1'b1;
		forever begin
			@(posedge clk);
			if (receiver_stalls && $urandom_range(0, 5) == 0) begin
				burst = $urandom_range(1, 7);
				out_ready <= 1'b0;
				repeat (burst) @(posedge clk);
				out_ready <= 1'b1;
			end else if (receiver_stalls && $urandom_range(0, 29) == 0) begin
				repeat ($urandom_range(20, 60)) @(posedge clk);
			end
		end
	end

	// Compare every accepted result with the oldest date still owed
	always @(posedge clk) begin : result_check
		shifted_date_t seen;
		shifted_date_t want;
		if (arst_n && out_valid && out_ready) begin
			seen.year      = end_year;
			seen.month     = end_month;
			seen.day       = end_day;
			seen.hour      = end_hour;
			seen.minute    = end_minute;
			seen.total     = total_minutes;
			seen.past_span = out_of_range;
			if (shifted_dates_due.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("%0t: result with nothing owed: %0d-%0d-%0d %0d:%0d total %0d span %0b",
						$realtime, seen.year, seen.month, seen.day, seen.hour,
						seen.minute, seen.total, seen.past_span);
			end else begin
				want = shifted_dates_due.pop_front();
				if (seen.year != want.year || seen.month != want.month ||
						seen.day != want.day || seen.hour != want.hour ||
						seen.minute != want.minute || seen.total != want.total ||
						seen.past_span != want.past_span) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS) begin
						$write("%0t: expected %0d-%0d-%0d %0d:%0d total %0d span %0b,",
							$realtime, want.year, want.month, want.day, want.hour,
							want.minute, want.total, want.past_span);
						$display(" got %0d-%0d-%0d %0d:%0d total %0d span %0b",
							seen.year, seen.month, seen.day, seen.hour, seen.minute,
							seen.total, seen.past_span);
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Field extremes: all zero, all ones, first and last minute of the span
	task automatic test_field_extremes();
		send_date(make_stamp(2000, 1, 1, 0, 0, 0));
		send_date(make_stamp(2000, 1, 1, 0, 0, 26'h3FFFFFF));
		send_date(make_stamp(2127, 12, 31, 23, 59, 0));
		// step off the end of the span
		send_date(make_stamp(2127, 12, 31, 23, 59, 1));
		send_date(make_stamp(2127, 1, 1, 0, 0, 26'h3FFFFFF));
		// year zero with month and day zero
		send_date(make_stamp(0, 0, 0, 0, 0, 0));
		// every input bit set: year and minute count both saturate
		send_date(make_stamp(4095, 15, 31, 31, 63, 26'h3FFFFFF));
		send_date(make_stamp(4095, 12, 31, 23, 59, 0));
	endtask

	// Leap rules, years below the base and fields past their normal range
	task automatic test_calendar_edges();
		// below the base: only the February of the year itself counts
		send_date(make_stamp(1996, 3, 1, 0, 0, 0));
		send_date(make_stamp(1900, 3, 1, 0, 0, 0));
		send_date(make_stamp(1999, 12, 31, 23, 59, 1));
		// leap day, skipped century leap day, new year
		send_date(make_stamp(2000, 2, 28, 23, 59, 1));
		send_date(make_stamp(2100, 2, 28, 23, 59, 1));
		send_date(make_stamp(2000, 12, 31, 23, 59, 1));
		send_date(make_stamp(2004, 2, 29, 0, 0, 365 * MIN_PER_DAY));
		// day, hour and minute carry as they stand
		send_date(make_stamp(2001, 2, 30, 0, 0, 0));
		send_date(make_stamp(2010, 6, 31, 24, 60, 0));
		// month above twelve reads as December
		send_date(make_stamp(2003, 13, 5, 10, 10, 0));
		// minute count saturates while the date stays exact
		send_date(make_stamp(2300, 6, 15, 12, 30, 100));
	endtask

	// Random dates with gaps and stalls; every wide_every-th item spans the
	// whole year field
	task automatic test_random_dates(int count, int wide_every);
		for (int i = 0; i < count; i++)
			send_date(random_date_stamp(i % wide_every == wide_every - 1));
	endtask

	// Hold the sender until the block has returned everything it owes
	task automatic test_drain_pause();
		for (int i = 0; i < 5; i++)
			send_date(random_date_stamp(1'b0));
		in_valid <= 1'b0;
		while (shifted_dates_due.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	// Full rate on both sides to close the run
	task automatic test_steady_flow(int count);
		sender_gaps     = 1'b0;
		receiver_stalls = 1'b0;
		for (int i = 0; i < count; i++)
			send_date(random_date_stamp(1'b0));
	endtask

	initial begin : run_regression
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		start_year     = '0;
		start_month    = '0;
		start_day      = '0;
		start_hour     = '0;
		start_minute   = '0;
		minutes_to_add = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_field_extremes();
		test_calendar_edges();
		test_random_dates(300, 40);
		test_drain_pause();
		test_random_dates(250, 40);
		test_steady_flow(60);

		// Drop valid, wait for the last result, then watch for stray ones
		in_valid <= 1'b0;
		while (shifted_dates_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && shifted_dates_due.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Generous ceiling on the whole run
	initial begin : watchdog
		#30_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
